### hw/rtl/vfqp_pkg.sv
// Shared types and constants for the voice frame queue packetizer.
// Used by every module of the block but vfqp_ram; depends on nothing else.
`default_nettype none

package vfqp_pkg;

    localparam int QUEUE_DEPTH     = 20;
    localparam int MAX_FRAMES      = 4;

    localparam int ADDR_W          = $clog2(QUEUE_DEPTH);
    localparam int CNT_W           = $clog2(QUEUE_DEPTH + 1);
    localparam int FCNT_W          = $clog2(MAX_FRAMES + 1);

    localparam int FRAME_W         = 64;
    localparam int SIZE_W          = 4;
    localparam int BYTE_W          = 8;
    localparam int BYTES_PER_FRAME = 8;
    localparam int BIDX_W          = $clog2(BYTES_PER_FRAME);
    localparam int BUDGET_W        = 16;
    localparam int MODE_W          = 3;
    localparam int FBYTES_W        = 4;
    localparam int HDR_CNT_W       = 4;
    localparam int PLEN_W          = 6;
    localparam int STATUS_W        = 3;
    localparam int TOT_W           = FCNT_W + FBYTES_W;
    localparam int RAM_W           = SIZE_W + FRAME_W;

    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 4;
    localparam logic [FBYTES_W-1:0] FBYTES_RESET = 4'd8;
    localparam logic [MODE_W-1:0]   MODE_RESET   = 3'd0;

    localparam int CMDQ_DEPTH      = 2;
    localparam int CMDQ_PTR_W      = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W      = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_INVALID = 3'd1,
        ST_FULL    = 3'd2,
        ST_NODATA  = 3'd3,
        ST_BYTE    = 3'd4
    } status_t;

    typedef enum logic {
        REQ_ENQ   = 1'b0,
        REQ_FETCH = 1'b1
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CODEC_MODE  = 1'b0,
        CFG_FRAME_BYTES = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_STATUS,
        BK_HDR,
        BK_READ,
        BK_BYTES
    } back_state_t;

    // One classified request handed from the front to the back.
    typedef struct packed {
        logic                is_pkt;
        status_t             status;
        logic [BYTE_W-1:0]   header;
        logic [FCNT_W-1:0]   frames;
    } cmd_t;

endpackage

`default_nettype wire

### hw/rtl/vfqp_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Standalone; read returns the old contents when both ports hit one address.
`default_nettype none

module vfqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hw/rtl/vfqp_cmd_fifo.sv
// Short command queue between the front classifier and the back sequencer.
// Depends on vfqp_pkg for the command type and depth.
`default_nettype none

module vfqp_cmd_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  vfqp_pkg::cmd_t  push_data,
    input  logic            pop,
    output vfqp_pkg::cmd_t  pop_data,
    output logic            full,
    output logic            empty
);

    import vfqp_pkg::*;

    cmd_t                  entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign full     = (count_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign empty    = (count_reg == '0);

endmodule

`default_nettype wire

### hw/rtl/vfqp_front.sv
// Front end: accepts request beats, holds configuration, tail and counts,
// writes frames to the store and classifies each request. Uses vfqp_pkg.
`default_nettype none

module vfqp_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [vfqp_pkg::FRAME_W-1:0]    frame_data,
    input  logic [vfqp_pkg::SIZE_W-1:0]     frame_size,
    input  logic [vfqp_pkg::BUDGET_W-1:0]   byte_budget,
    input  logic                            voice_active,
    input  logic                            cfg_wr_en,
    input  logic [vfqp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vfqp_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            frame_pop,
    input  logic                            cmdq_full,
    output logic                            cmd_push,
    output vfqp_pkg::cmd_t                  cmd_data,
    output logic                            ram_wr_en,
    output logic [vfqp_pkg::ADDR_W-1:0]     ram_wr_addr,
    output logic [vfqp_pkg::RAM_W-1:0]      ram_wr_data
);

    import vfqp_pkg::*;

    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [FBYTES_W-1:0] fbytes_reg, fbytes_next;
    logic [ADDR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    // Frames handed to the back end but not yet read out of the store.
    logic [CNT_W-1:0]    outst_reg, outst_next;

    logic [CNT_W:0]      phys;
    logic                enq_stall;
    logic                accept;
    logic                size_ok;
    logic                q_full;
    logic [FCNT_W-1:0]   f_cap;
    logic [TOT_W-1:0]    total;
    logic                cut;
    logic [FCNT_W-1:0]   fit_cnt;
    logic [FCNT_W-1:0]   frames;
    logic                do_store;
    logic                do_take;
    cmd_t                cmd;

    // Occupancy of the physical store includes frames still being read.
    assign phys      = {1'b0, count_reg} + {1'b0, outst_reg};
    assign enq_stall = (req_t'(req_type) == REQ_ENQ) && (outst_reg != '0) &&
                       (phys >= (CNT_W + 1)'(QUEUE_DEPTH));
    assign in_ready  = !cmdq_full && !enq_stall;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        size_ok = (frame_size != '0) && (frame_size <= SIZE_W'(BYTES_PER_FRAME));
        q_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
        f_cap   = (count_reg > CNT_W'(MAX_FRAMES)) ? FCNT_W'(MAX_FRAMES) :
                  FCNT_W'(count_reg);
        total   = TOT_W'(f_cap) * TOT_W'(fbytes_reg);
        cut     = (BUDGET_W'(total) > byte_budget) && (fbytes_reg != '0);
        // Largest n below f_cap with n frames fitting the budget.
        fit_cnt = '0;
        for (int n = 1; n < MAX_FRAMES; n++)
        begin
            if ((FCNT_W'(n) < f_cap) &&
                (BUDGET_W'(n) * BUDGET_W'(fbytes_reg) <= byte_budget))
            begin
                fit_cnt = fit_cnt + 1'b1;
            end
        end
        frames = cut ? fit_cnt : f_cap;
    end

    always_comb
    begin
        cmd.is_pkt = 1'b0;
        cmd.status = ST_INVALID;
        cmd.header = {voice_active, HDR_CNT_W'(frames), mode_reg};
        cmd.frames = frames;
        do_store   = 1'b0;
        do_take    = 1'b0;
        case (req_t'(req_type))
            REQ_ENQ:
            begin
                if (!size_ok)
                begin
                    cmd.status = ST_INVALID;
                end
                else if (q_full)
                begin
                    cmd.status = ST_FULL;
                end
                else
                begin
                    cmd.status = ST_OK;
                    do_store   = 1'b1;
                end
            end
            REQ_FETCH:
            begin
                if (byte_budget == '0)
                begin
                    cmd.status = ST_INVALID;
                end
                else if (frames == '0)
                begin
                    cmd.status = ST_NODATA;
                end
                else
                begin
                    cmd.is_pkt = 1'b1;
                    cmd.status = ST_BYTE;
                    do_take    = 1'b1;
                end
            end
            default:
            begin
                cmd.status = ST_INVALID;
            end
        endcase
    end

    assign cmd_push    = accept;
    assign cmd_data    = cmd;
    assign ram_wr_en   = accept && do_store;
    assign ram_wr_addr = tail_reg;
    assign ram_wr_data = {frame_size, frame_data};

    always_comb
    begin
        mode_next   = mode_reg;
        fbytes_next = fbytes_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        outst_next  = outst_reg;
        if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CODEC_MODE:  mode_next   = cfg_data[MODE_W-1:0];
                CFG_FRAME_BYTES: fbytes_next = cfg_data[FBYTES_W-1:0];
                default:         mode_next   = mode_reg;
            endcase
        end
        if (accept && do_store)
        begin
            tail_next  = (tail_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        if (accept && do_take)
        begin
            count_next = count_reg - CNT_W'(frames);
            outst_next = outst_reg + CNT_W'(frames);
        end
        if (frame_pop)
        begin
            outst_next = outst_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RESET;
            fbytes_reg <= FBYTES_RESET;
            tail_reg   <= '0;
            count_reg  <= '0;
            outst_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            fbytes_reg <= fbytes_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            outst_reg  <= outst_next;
        end
    end

    a_phys_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phys <= (CNT_W + 1)'(QUEUE_DEPTH))
        else $error("store occupancy above depth");

    a_wr_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (phys < (CNT_W + 1)'(QUEUE_DEPTH)))
        else $error("frame written into a slot not yet read");

    a_pop_owed: assert property (@(posedge clk) disable iff (!rst_n)
        frame_pop |-> (outst_reg != '0))
        else $error("frame read with no frame outstanding");

endmodule

`default_nettype wire

### hw/rtl/vfqp_back.sv
// Back end: takes classified commands, reads frames at the head of the store
// and streams status and packet beats through an output register. Uses vfqp_pkg.
`default_nettype none

module vfqp_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    output logic                           cmd_pop,
    input  vfqp_pkg::cmd_t                 cmd_data,
    output logic                           ram_rd_en,
    output logic [vfqp_pkg::ADDR_W-1:0]    ram_rd_addr,
    input  logic [vfqp_pkg::RAM_W-1:0]     ram_rd_data,
    output logic                           frame_pop,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [vfqp_pkg::STATUS_W-1:0]  status,
    output logic [vfqp_pkg::BYTE_W-1:0]    data_byte,
    output logic                           last,
    output logic [vfqp_pkg::PLEN_W-1:0]    packet_length
);

    import vfqp_pkg::*;

    back_state_t         state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [FCNT_W-1:0]   left_reg, left_next;
    logic [ADDR_W-1:0]   head_reg, head_next;
    logic [BIDX_W-1:0]   bidx_reg, bidx_next;
    logic [PLEN_W-1:0]   plen_reg, plen_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg;
    logic [BYTE_W-1:0]   out_byte_reg;
    logic                out_last_reg;
    logic [PLEN_W-1:0]   out_plen_reg;

    logic                load_ok;
    logic [SIZE_W-1:0]   rd_size;
    logic [FRAME_W-1:0]  rd_frame;
    logic                byte_final;
    logic [BYTE_W-1:0]   cur_byte;
    logic [PLEN_W-1:0]   plen_inc;
    logic                emit;
    status_t             emit_status;
    logic [BYTE_W-1:0]   emit_byte;
    logic                emit_last;
    logic [PLEN_W-1:0]   emit_plen;

    assign load_ok    = !out_valid_reg || out_ready;
    assign rd_size    = ram_rd_data[RAM_W-1 -: SIZE_W];
    assign rd_frame   = ram_rd_data[FRAME_W-1:0];
    assign byte_final = (SIZE_W'(bidx_reg) + 1'b1) == rd_size;
    assign cur_byte   = rd_frame[32'(bidx_reg) * BYTE_W +: BYTE_W];
    assign plen_inc   = plen_reg + 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = cmd_data.is_pkt ? BK_HDR : BK_STATUS;
                end
            end
            BK_STATUS:
            begin
                if (load_ok)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_HDR:
            begin
                if (load_ok)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                state_next = BK_BYTES;
            end
            BK_BYTES:
            begin
                if (load_ok && byte_final)
                begin
                    state_next = (left_reg == '0) ? BK_IDLE : BK_READ;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop     = 1'b0;
        ram_rd_en   = 1'b0;
        frame_pop   = 1'b0;
        emit        = 1'b0;
        emit_status = ST_BYTE;
        emit_byte   = '0;
        emit_last   = 1'b0;
        emit_plen   = '0;
        cmd_next    = cmd_reg;
        left_next   = left_reg;
        head_next   = head_reg;
        bidx_next   = bidx_reg;
        plen_next   = plen_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop   = 1'b1;
                    cmd_next  = cmd_data;
                    left_next = cmd_data.frames;
                end
            end
            BK_STATUS:
            begin
                emit        = load_ok;
                emit_status = cmd_reg.status;
                emit_last   = 1'b1;
            end
            BK_HDR:
            begin
                emit      = load_ok;
                emit_byte = cmd_reg.header;
                if (load_ok)
                begin
                    plen_next = PLEN_W'(1);
                end
            end
            BK_READ:
            begin
                // The slot is free once this read is registered.
                ram_rd_en = 1'b1;
                frame_pop = 1'b1;
                left_next = left_reg - 1'b1;
                head_next = (head_reg == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
                bidx_next = '0;
            end
            BK_BYTES:
            begin
                emit      = load_ok;
                emit_byte = cur_byte;
                emit_last = byte_final && (left_reg == '0);
                emit_plen = emit_last ? plen_inc : '0;
                if (load_ok)
                begin
                    plen_next = plen_inc;
                    if (!byte_final)
                    begin
                        bidx_next = bidx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !out_ready;
        end
    end

    assign ram_rd_addr = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            left_reg      <= '0;
            head_reg      <= '0;
            bidx_reg      <= '0;
            plen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            left_reg      <= left_next;
            head_reg      <= head_next;
            bidx_reg      <= bidx_next;
            plen_reg      <= plen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_byte_reg   <= emit_byte;
            out_last_reg   <= emit_last;
            out_plen_reg   <= emit_plen;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign data_byte     = out_byte_reg;
    assign last          = out_last_reg;
    assign packet_length = out_plen_reg;

endmodule

`default_nettype wire

### hw/rtl/voice_frame_queue_packetizer_core.sv
// Voice frame queue packetizer. An enqueue request returns one status beat;
// the front accepts a new request every cycle while the two-entry command
// queue has room and no enqueue is held for store space. The back end takes
// each command from that queue in its idle state. A fetch produces one
// header beat and then, for each frame taken, a read of the frame store
// through its single read port and one beat per stored byte. A packet holds
// at most four frames. An enqueue that finds the store physically full
// waits until the back end has read out the frames of earlier fetches. No
// clearing pass is needed after reset. Depends on vfqp_pkg and the vfqp_*
// modules.
`default_nettype none

module voice_frame_queue_packetizer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [vfqp_pkg::FRAME_W-1:0]    frame_data,
    input  logic [vfqp_pkg::SIZE_W-1:0]     frame_size,
    input  logic [vfqp_pkg::BUDGET_W-1:0]   byte_budget,
    input  logic                            voice_active,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [vfqp_pkg::STATUS_W-1:0]   status,
    output logic [vfqp_pkg::BYTE_W-1:0]     data_byte,
    output logic                            last,
    output logic [vfqp_pkg::PLEN_W-1:0]     packet_length,
    input  logic                            cfg_wr_en,
    input  logic [vfqp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [vfqp_pkg::CFG_DATA_W-1:0] cfg_data
);

    import vfqp_pkg::*;

    logic                cmdq_full;
    logic                cmdq_empty;
    logic                cmd_push;
    logic                cmd_pop;
    cmd_t                cmd_in;
    cmd_t                cmd_out;
    logic                frame_pop;
    logic                ram_wr_en;
    logic [ADDR_W-1:0]   ram_wr_addr;
    logic [RAM_W-1:0]    ram_wr_data;
    logic                ram_rd_en;
    logic [ADDR_W-1:0]   ram_rd_addr;
    logic [RAM_W-1:0]    ram_rd_data;

    vfqp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .frame_data   (frame_data),
        .frame_size   (frame_size),
        .byte_budget  (byte_budget),
        .voice_active (voice_active),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_pop    (frame_pop),
        .cmdq_full    (cmdq_full),
        .cmd_push     (cmd_push),
        .cmd_data     (cmd_in),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data)
    );

    vfqp_cmd_fifo u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .full      (cmdq_full),
        .empty     (cmdq_empty)
    );

    vfqp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    vfqp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (!cmdq_empty),
        .cmd_pop       (cmd_pop),
        .cmd_data      (cmd_out),
        .ram_rd_en     (ram_rd_en),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data),
        .frame_pop     (frame_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .data_byte     (data_byte),
        .last          (last),
        .packet_length (packet_length)
    );

endmodule

`default_nettype wire
